@@ design/mcmp_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI channel message parser package
// Shared types and constants for the parser and its stages.
// ----------------------------------------------------------------------------
package mcmp_pkg;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Position of the parser within a message.
    typedef enum logic [1:0] {
        POS_IDLE   = 2'd0,
        POS_FIRST  = 2'd1,
        POS_SECOND = 2'd2,
        POS_LOCKED = 2'd3
    } pos_t;

    // Input function codes.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Status nibbles of interest.
    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
    localparam logic [3:0] TYPE_PRESSURE = 4'hD;
    localparam logic [3:0] TYPE_PITCH    = 4'hE;

    // Output kind codes for pitch wheel and for no message.
    localparam logic [2:0] KIND_PITCH = 3'd6;
    localparam logic [2:0] KIND_NONE  = 3'd7;

    // One input item as held in the input register.
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } item_t;

endpackage

@@ design/mcmp_ifs.sv @@
// ----------------------------------------------------------------------------
// MIDI channel message parser interfaces
// Valid/ready channels for input items and parsed messages.
// ----------------------------------------------------------------------------
interface mcmp_byte_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface mcmp_msg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  msg_kind;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [15:0] pitch_value;

    modport source (output valid, output msg_kind, output channel, output first_data,
                    output second_data, output pitch_value, input ready);
    modport sink   (input valid, input msg_kind, input channel, input first_data,
                    input second_data, input pitch_value, output ready);
endinterface

@@ design/mcmp_in_stage.sv @@
// ----------------------------------------------------------------------------
// MIDI parser input stage
// Registers one input transaction and hands it to the parser core.
// ----------------------------------------------------------------------------
module mcmp_in_stage
    import mcmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mcmp_byte_if.sink     rx,
    input  logic          take,
    output logic          item_valid,
    output item_t         item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register can be refilled in the same cycle that the core consumes it.
    assign rx.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (rx.ready)
        begin
            valid_next = rx.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            item_reg.func      <= rx.func;
            item_reg.data_byte <= rx.data_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/mcmp_core.sv @@
// ----------------------------------------------------------------------------
// MIDI parser core
// Message state, timeout countdown and the registered result.
// ----------------------------------------------------------------------------
module mcmp_core
    import mcmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    input  logic          item_valid,
    input  item_t         item,
    output logic          take,
    mcmp_msg_if.source    msg
);

    pos_t        pos_reg,     pos_next;
    logic [3:0]  kind_reg,    kind_next;
    logic [3:0]  chan_reg,    chan_next;
    logic [7:0]  first_reg,   first_next;
    logic [15:0] cd_reg,      cd_next;
    logic [15:0] timeout_reg;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_kind_reg,  out_kind_next;
    logic [3:0]  out_chan_reg,  out_chan_next;
    logic [7:0]  out_first_reg, out_first_next;
    logic [7:0]  out_second_reg, out_second_next;

    logic        emit;
    logic [15:0] cd_dec;
    logic        type_known;
    logic        type_short;

    // An item is processed only when the result register has room.
    assign take = item_valid && (!out_valid_reg || msg.ready);

    assign cd_dec     = (cd_reg == 16'd0) ? 16'd0 : cd_reg - 16'd1;
    assign type_known = (kind_reg >= TYPE_NOTE_OFF) && (kind_reg <= TYPE_PITCH);
    assign type_short = (kind_reg == TYPE_PROGRAM) || (kind_reg == TYPE_PRESSURE);

    always_comb
    begin
        pos_next        = pos_reg;
        kind_next       = kind_reg;
        chan_next       = chan_reg;
        first_next      = first_reg;
        cd_next         = cd_reg;
        emit            = 1'b0;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        if (take)
        begin
            if (item.func == FUNC_TICK)
            begin
                cd_next = cd_dec;
                if (cd_dec == 16'd0)
                begin
                    pos_next = POS_IDLE;
                end
            end
            else
            begin
                cd_next = timeout_reg;
                case (pos_reg)
                    POS_IDLE:
                    begin
                        kind_next = item.data_byte[7:4];
                        chan_next = item.data_byte[3:0];
                        pos_next  = POS_FIRST;
                    end
                    POS_FIRST:
                    begin
                        if (type_short)
                        begin
                            pos_next        = POS_IDLE;
                            emit            = 1'b1;
                            out_first_next  = item.data_byte;
                            out_second_next = 8'd0;
                        end
                        else if (type_known)
                        begin
                            first_next = item.data_byte;
                            pos_next   = POS_SECOND;
                        end
                        else
                        begin
                            pos_next = POS_LOCKED;
                        end
                    end
                    POS_SECOND:
                    begin
                        pos_next        = POS_IDLE;
                        emit            = 1'b1;
                        out_first_next  = first_reg;
                        out_second_next = item.data_byte;
                    end
                    default:
                    begin
                        pos_next = pos_reg;
                    end
                endcase
            end
        end
    end

    // Known types 8 to 14 map onto kinds 0 to 6 by their low three bits.
    always_comb
    begin
        out_kind_next  = out_kind_reg;
        out_chan_next  = out_chan_reg;
        out_valid_next = out_valid_reg && !msg.ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = kind_reg[2:0];
            out_chan_next  = chan_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_IDLE;
            kind_reg      <= 4'd0;
            chan_reg      <= 4'd0;
            first_reg     <= 8'd0;
            cd_reg        <= TIMEOUT_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            chan_reg      <= chan_next;
            first_reg     <= first_next;
            cd_reg        <= cd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg   <= out_kind_next;
        out_chan_reg   <= out_chan_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
    end

    assign msg.valid       = out_valid_reg;
    assign msg.msg_kind    = out_kind_reg;
    assign msg.channel     = out_chan_reg;
    assign msg.first_data  = out_first_reg;
    assign msg.second_data = out_second_reg;
    assign msg.pitch_value = (out_kind_reg == KIND_PITCH) ?
                             {out_second_reg, out_first_reg} : 16'd0;

    // A new result only ever follows a processed transaction.
    a_result_from_take: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(take))
        else $error("result appeared without a processed transaction");

    // A received byte reloads the countdown from the timeout register.
    a_byte_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        take && (item.func == FUNC_BYTE) |=> cd_reg == $past(timeout_reg))
        else $error("countdown not reloaded by a byte");

    // A tick that exhausts the countdown returns the parser to idle.
    a_timeout_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && (item.func == FUNC_TICK) && (cd_reg <= 16'd1) |=> pos_reg == POS_IDLE)
        else $error("parser not idle after timeout");

    // A locked parser never produces a result.
    a_locked_silent: assert property (@(posedge clk) disable iff (!rst_n)
        take && (pos_reg == POS_LOCKED) |-> !emit)
        else $error("result emitted while locked");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_kind_reg != KIND_NONE)
        else $error("result kind out of range");

endmodule

@@ design/midi_channel_message_parser_unit.sv @@
// ----------------------------------------------------------------------------
// MIDI channel message parser unit
// Assembles channel voice messages from received bytes, with a tick timeout.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  rx        in         func, data_byte (byte or timer tick)
//  msg       out        msg_kind, channel, first_data, second_data, pitch_value
//  cfg       in         cfg_wr_en, cfg_wr_data (timeout_ticks)
//
//  One transaction per cycle is accepted while the result side is not stalled;
//  a result passes through the input register, then the result register.
//  Reset clears the parser to idle and loads 1000 into timeout and countdown.
//  A stalled result register holds the core; the input register keeps or takes
//  one transaction and deasserts rx.ready while it is full.
// ----------------------------------------------------------------------------
module midi_channel_message_parser_unit
    import mcmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    mcmp_byte_if.sink     rx,
    mcmp_msg_if.source    msg
);

    logic  take;
    logic  item_valid;
    item_t item;

    mcmp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mcmp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .take        (take),
        .msg         (msg)
    );

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// MIDI channel message parser unit testbench
// Drives received bytes and timer ticks into the parser, predicts parsed
// messages from the directed table or a behavioral model of the byte framing
// and timeout, and checks each message transaction against the predicted one in order.
// ----------------------------------------------------------------------------
module testbench;
    import mcmp_pkg::*;

    localparam int RUN_LIMIT         = 5000000;
    localparam int ITEMS_PER_PHASE   = 240;
    localparam int NUM_PHASES        = 6;
    localparam int DRAIN_LIMIT       = 20000;
    localparam int SETTLE_CYCLES     = 8;
    localparam int NOISE_MAX_TIMEOUT = 64;
    localparam int N_DIRECTED        = 30;

    // Status nibbles not named in the package.
    localparam logic [3:0] TYPE_NOTE_ON = 4'h9;
    localparam logic [3:0] TYPE_POLY    = 4'hA;
    localparam logic [3:0] TYPE_CONTROL = 4'hB;
    localparam logic [3:0] TYPE_UNKNOWN = 4'hF;

    // Message kinds other than pitch wheel.
    localparam logic [2:0] KIND_NOTE_OFF   = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON    = 3'd1;
    localparam logic [2:0] KIND_PROGRAM    = 3'd4;
    localparam logic [2:0] KIND_CHAN_PRESS = 3'd5;

    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_CFG  = 1'b1;

    typedef struct packed {
        logic [2:0]  msg_kind;
        logic [3:0]  channel;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [15:0] pitch_value;
    } midi_msg_t;

    localparam midi_msg_t NO_MSG = '0;

    typedef struct packed {
        logic        is_cfg;
        logic        func;
        logic [15:0] arg;
        logic        typed;
        midi_msg_t   want;
    } row_t;

    localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_ITEM, FUNC_BYTE, 16'h0090, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0000, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h007F, 1'b1,
          '{KIND_NOTE_ON, 4'd0, 8'h00, 8'h7F, 16'h0000}},
        '{ROW_ITEM, FUNC_BYTE, 16'h00EF, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h00FF, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h00FF, 1'b1,
          '{KIND_PITCH, 4'd15, 8'hFF, 8'hFF, 16'hFFFF}},
        '{ROW_ITEM, FUNC_BYTE, 16'h00C3, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0055, 1'b1,
          '{KIND_PROGRAM, 4'd3, 8'h55, 8'h00, 16'h0000}},
        '{ROW_ITEM, FUNC_BYTE, 16'h00D0, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0000, 1'b1,
          '{KIND_CHAN_PRESS, 4'd0, 8'h00, 8'h00, 16'h0000}},
        '{ROW_ITEM, FUNC_BYTE, 16'h00A5, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0012, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0034, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h00B7, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0001, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0040, 1'b0, NO_MSG},
        // A tick ignores its data byte.
        '{ROW_ITEM, FUNC_TICK, 16'h00FF, 1'b0, NO_MSG},
        // Status without its top bit is still a status; type 3 locks the parser.
        '{ROW_ITEM, FUNC_BYTE, 16'h003C, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0011, 1'b0, NO_MSG},
        '{ROW_CFG,  FUNC_BYTE, 16'd2,    1'b0, NO_MSG},
        // The write leaves the running countdown alone; this byte reloads it.
        '{ROW_ITEM, FUNC_BYTE, 16'h00F0, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_TICK, 16'h0000, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_TICK, 16'h0000, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_TICK, 16'h0000, 1'b0, NO_MSG},
        '{ROW_CFG,  FUNC_BYTE, 16'd0,    1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h009F, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_TICK, 16'h0000, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0080, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0000, 1'b0, NO_MSG},
        '{ROW_ITEM, FUNC_BYTE, 16'h0000, 1'b1,
          '{KIND_NOTE_OFF, 4'd0, 8'h00, 8'h00, 16'h0000}}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    mcmp_byte_if rx ();
    mcmp_msg_if  msg ();

    midi_channel_message_parser_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (rx),
        .msg         (msg)
    );

    always #5 clk = ~clk;

    // Parser model state.
    pos_t        pos_now         = POS_IDLE;
    logic [3:0]  held_type       = 4'h0;
    logic [3:0]  held_chan       = 4'h0;
    logic [7:0]  held_first_byte = 8'h0;
    logic [15:0] count_left      = TIMEOUT_RESET;
    logic [15:0] timeout_reload  = TIMEOUT_RESET;

    midi_msg_t pending_msgs [$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        gap_pct    = 20;
    bit        quiet_tail = 1'b0;

    function automatic midi_msg_t build_msg(input logic [3:0] status_type,
                                            input logic [7:0] lo, input logic [7:0] hi);
        logic [3:0] offset;
        midi_msg_t  m;
        offset        = status_type - TYPE_NOTE_OFF;
        m.msg_kind    = offset[2:0];
        m.channel     = held_chan;
        m.first_data  = lo;
        m.second_data = hi;
        m.pitch_value = (m.msg_kind == KIND_PITCH) ? {hi, lo} : 16'h0000;
        return m;
    endfunction

    function automatic string fmt_msg(input midi_msg_t m);
        return $sformatf("kind %0d ch %0d %02h %02h %04h", m.msg_kind, m.channel,
                         m.first_data, m.second_data, m.pitch_value);
    endfunction

    // Advances the model by one accepted input transaction.
    function automatic bit parse_midi_item(input logic f, input logic [7:0] b,
                                           output midi_msg_t m);
        m = NO_MSG;
        if (f == FUNC_TICK)
        begin
            if (count_left != 16'd0)
                count_left = count_left - 16'd1;
            if (count_left == 16'd0)
                pos_now = POS_IDLE;
            return 1'b0;
        end
        count_left = timeout_reload;
        case (pos_now)
            POS_IDLE:
            begin
                held_type = b[7:4];
                held_chan = b[3:0];
                pos_now   = POS_FIRST;
            end
            POS_FIRST:
            begin
                if (held_type == TYPE_PROGRAM || held_type == TYPE_PRESSURE)
                begin
                    pos_now = POS_IDLE;
                    m = build_msg(held_type, b, 8'h00);
                    return 1'b1;
                end
                if (held_type >= TYPE_NOTE_OFF && held_type <= TYPE_PITCH)
                begin
                    held_first_byte = b;
                    pos_now = POS_SECOND;
                end
                else
                begin
                    pos_now = POS_LOCKED;
                end
            end
            POS_SECOND:
            begin
                pos_now = POS_IDLE;
                m = build_msg(held_type, held_first_byte, b);
                return 1'b1;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    task automatic log_failure(input string what);
        if (fail_count < 10)
            $display("%0t: %s", $time, what);
        fail_count++;
    endtask

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic push_item(input logic f, input logic [7:0] b,
                             input logic typed, input midi_msg_t want);
        midi_msg_t m;
        bit        hit;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        rx.valid     <= 1'b1;
        rx.func      <= f;
        rx.data_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        hit = parse_midi_item(f, b, m);
        if (typed)
            pending_msgs.push_back(want);
        else if (hit)
            pending_msgs.push_back(m);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_item(FUNC_BYTE, b, 1'b0, NO_MSG);
    endtask

    task automatic send_tick();
        push_item(FUNC_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_MSG);
    endtask

    task automatic wait_results_done();
        int guard;
        guard = 0;
        rx.valid <= 1'b0;
        while (pending_msgs.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        // Bytes that complete no message may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        wait_results_done();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        timeout_reload  = ticks;
    endtask

    task automatic send_voice_message();
        logic [3:0] ty;
        int         n_data;
        ty     = 4'(TYPE_NOTE_OFF + 4'($urandom_range(0, 6)));
        n_data = (ty == TYPE_PROGRAM || ty == TYPE_PRESSURE) ? 1 : 2;
        send_byte({ty, 4'($urandom_range(0, 15))});
        for (int i = 0; i < n_data; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3)) send_tick();
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Only used with short timeouts, so a locked parser is always freed again.
    task automatic send_noise();
        int         pick;
        logic [3:0] ty;
        pick = $urandom_range(0, 3);
        case (pick)
            0: send_byte(8'($urandom_range(0, 255)));
            1:
            begin
                ty = 4'($urandom_range(0, 8));
                if (ty == 4'd8)
                    ty = TYPE_UNKNOWN;
                send_byte({ty, 4'($urandom_range(0, 15))});
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
            2: repeat ($urandom_range(1, int'(timeout_reload) + 2)) send_tick();
            default:
            begin
                case ($urandom_range(0, 4))
                    0: ty = TYPE_NOTE_OFF;
                    1: ty = TYPE_NOTE_ON;
                    2: ty = TYPE_POLY;
                    3: ty = TYPE_CONTROL;
                    default: ty = TYPE_PITCH;
                endcase
                send_byte({ty, 4'($urandom_range(0, 15))});
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    initial
    begin
        int         target;
        logic [15:0] ticks;
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= 16'h0000;
        rx.valid     <= 1'b0;
        rx.func      <= FUNC_BYTE;
        rx.data_byte <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED_ROWS[i].is_cfg == ROW_CFG)
                set_timeout(DIRECTED_ROWS[i].arg);
            else
                push_item(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].arg[7:0],
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        // Long timeouts come first, while the parser is still in step with the
        // stream; short ones follow, where noise and broken messages are safe.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: ticks = 16'hFFFF;
                1: ticks = 16'($urandom_range(300, 60000));
                2: ticks = 16'd0;
                3: ticks = 16'd1;
                4: ticks = 16'($urandom_range(2, 8));
                default: ticks = 16'($urandom_range(9, 40));
            endcase
            quiet_tail = (ph == NUM_PHASES - 1);
            gap_pct    = (quiet_tail || ph == 1) ? 0 : $urandom_range(10, 40);
            set_timeout(ticks);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                if (timeout_reload <= NOISE_MAX_TIMEOUT && $urandom_range(0, 3) == 0)
                begin
                    send_noise();
                end
                else
                begin
                    if (timeout_reload <= NOISE_MAX_TIMEOUT && $urandom_range(0, 4) != 0)
                        while (pos_now != POS_IDLE)
                            send_tick();
                    send_voice_message();
                end
            end
        end

        wait_results_done();
        if (pending_msgs.size() != 0)
            log_failure($sformatf("%0d expected messages never arrived",
                                  pending_msgs.size()));
        if (fail_count == 0)
            $display("midi_channel_message_parser_unit test passed");
        else
            $display("midi_channel_message_parser_unit test failed");
        $finish;
    end

    // Result side backpressure: stretches of ready with short random stalls, and ready throughout the last phase.
    initial
    begin
        msg.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (quiet_tail)
            begin
                msg.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                msg.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
                if ($urandom_range(0, 1) == 1)
                begin
                    msg.ready <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_messages
        midi_msg_t seen;
        midi_msg_t want;
        if (rst_n && msg.valid && msg.ready)
        begin
            seen = {msg.msg_kind, msg.channel, msg.first_data, msg.second_data,
                    msg.pitch_value};
            if (pending_msgs.size() == 0)
            begin
                log_failure($sformatf("unexpected message %s", fmt_msg(seen)));
            end
            else
            begin
                want = pending_msgs.pop_front();
                if (seen.msg_kind !== want.msg_kind || seen.channel !== want.channel ||
                    seen.first_data !== want.first_data ||
                    seen.second_data !== want.second_data ||
                    seen.pitch_value !== want.pitch_value)
                    log_failure($sformatf("message mismatch: expected %s, got %s",
                                          fmt_msg(want), fmt_msg(seen)));
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("midi_channel_message_parser_unit test failed");
        $finish;
    end

endmodule
